// ===== sv/rgbhsv_pkg.sv =====
// Shared types and constants of the RGB to HSV range converter.
`timescale 1ns / 1ps

package rgbhsv_pkg;

	localparam int CH_W      = 8;
	localparam int HUE_NUM_W = 17;
	localparam int SAT_NUM_W = 16;
	localparam int QUO_W     = 9;
	localparam int IDX_W     = 2;

	localparam logic [IDX_W-1:0] REG_HUE_MARGIN = 2'd0;
	localparam logic [IDX_W-1:0] REG_SAT_MARGIN = 2'd1;
	localparam logic [IDX_W-1:0] REG_VAL_MARGIN = 2'd2;

	localparam logic [CH_W-1:0] MARGIN_RESET = 8'd20;
	localparam logic [CH_W-1:0] HUE_CAP      = 8'd180;
	localparam logic [CH_W-1:0] CH_CAP       = 8'd255;

	localparam logic [17:0] DEG_60  = 18'd60;
	localparam logic [17:0] DEG_120 = 18'd120;
	localparam logic [17:0] DEG_240 = 18'd240;
	localparam logic [17:0] DEG_360 = 18'd360;
	localparam logic [SAT_NUM_W-1:0] SAT_SCALE = 16'd255;

	// data handed from cell to cell: two restoring divisions side by side
	typedef struct packed {
		logic                 hue_zero;
		logic                 sat_zero;
		logic [CH_W-1:0]      val;
		logic [HUE_NUM_W-1:0] hue_rem;
		logic [CH_W-1:0]      hue_div;
		logic [QUO_W-1:0]     hue_quo;
		logic [SAT_NUM_W-1:0] sat_rem;
		logic [CH_W-1:0]      sat_div;
		logic [QUO_W-1:0]     sat_quo;
	} cell_t;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] sat;
		logic [CH_W-1:0] val;
	} margin_t;

endpackage

// ===== sv/rgbhsv_front.sv =====
// Front stage: channel max/min, hue sector and the two division numerators.
`timescale 1ns / 1ps

module rgbhsv_front import rgbhsv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	output logic            vld_s1,
	output cell_t           data_s1
);

	logic [CH_W-1:0] mx;
	logic [CH_W-1:0] mn;
	logic [CH_W-1:0] d;
	logic [17:0]     hnum;
	cell_t           nxt;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		d = mx - mn;

		// numerator of the hue quotient; always non-negative
		priority if (red == mx) begin
			if (green >= blue) begin
				hnum = (18'(green) - 18'(blue)) * DEG_60;
			end else begin
				hnum = 18'(d) * DEG_360 - (18'(blue) - 18'(green)) * DEG_60;
			end
		end else if (green == mx) begin
			hnum = 18'(d) * DEG_120 + 18'(blue) * DEG_60 - 18'(red) * DEG_60;
		end else begin
			hnum = 18'(d) * DEG_240 + 18'(red) * DEG_60 - 18'(green) * DEG_60;
		end

		nxt.hue_zero = (d == '0);
		nxt.sat_zero = (mx == '0);
		nxt.val      = mx;
		nxt.hue_rem  = hnum[HUE_NUM_W-1:0];
		nxt.hue_div  = d;
		nxt.hue_quo  = '0;
		nxt.sat_rem  = SAT_NUM_W'(d) * SAT_SCALE;
		nxt.sat_div  = mx;
		nxt.sat_quo  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// ===== sv/rgbhsv_cell.sv =====
// One division cell: settles one quotient bit of the hue and saturation lanes.
`timescale 1ns / 1ps

module rgbhsv_cell import rgbhsv_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_i,
	input  cell_t data_i,
	output logic  vld_o,
	output cell_t data_o
);

	logic [HUE_NUM_W-1:0] hue_sh;
	logic [SAT_NUM_W-1:0] sat_sh;
	cell_t                nxt;

	always_comb begin
		hue_sh = HUE_NUM_W'(data_i.hue_div) << BIT;
		sat_sh = SAT_NUM_W'(data_i.sat_div) << BIT;
		nxt    = data_i;
		if (data_i.hue_rem >= hue_sh) begin
			nxt.hue_rem      = data_i.hue_rem - hue_sh;
			nxt.hue_quo[BIT] = 1'b1;
		end
		if (data_i.sat_rem >= sat_sh) begin
			nxt.sat_rem      = data_i.sat_rem - sat_sh;
			nxt.sat_quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_o <= nxt;
		end
	end

endmodule

// ===== sv/rgbhsv_back.sv =====
// Back stage: final hue and saturation, window bounds and the output register.
`timescale 1ns / 1ps

module rgbhsv_back import rgbhsv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  cell_t           data_i,
	input  margin_t         margin,
	output logic            vld_q,
	output logic [CH_W-1:0] hue_q,
	output logic [CH_W-1:0] sat_q,
	output logic [CH_W-1:0] val_q,
	output logic [CH_W-1:0] hue_low_q,
	output logic [CH_W-1:0] hue_high_q,
	output logic [CH_W-1:0] sat_low_q,
	output logic [CH_W-1:0] sat_high_q,
	output logic [CH_W-1:0] val_low_q,
	output logic [CH_W-1:0] val_high_q
);

	logic [CH_W-1:0] hue_c;
	logic [CH_W-1:0] sat_c;
	logic [CH_W:0]   hue_sum;
	logic [CH_W:0]   sat_sum;
	logic [CH_W:0]   val_sum;

	always_comb begin
		hue_c   = data_i.hue_zero ? '0 : data_i.hue_quo[QUO_W-1:1];
		sat_c   = data_i.sat_zero ? '0 : data_i.sat_quo[CH_W-1:0];
		hue_sum = {1'b0, hue_c} + {1'b0, margin.hue};
		sat_sum = {1'b0, sat_c} + {1'b0, margin.sat};
		val_sum = {1'b0, data_i.val} + {1'b0, margin.val};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q      <= hue_c;
			sat_q      <= sat_c;
			val_q      <= data_i.val;
			hue_low_q  <= (hue_c > margin.hue) ? hue_c - margin.hue : '0;
			sat_low_q  <= (sat_c > margin.sat) ? sat_c - margin.sat : '0;
			val_low_q  <= (data_i.val > margin.val) ? data_i.val - margin.val : '0;
			hue_high_q <= (hue_sum > {1'b0, HUE_CAP}) ? HUE_CAP : hue_sum[CH_W-1:0];
			sat_high_q <= (sat_sum > {1'b0, CH_CAP}) ? CH_CAP : sat_sum[CH_W-1:0];
			val_high_q <= (val_sum > {1'b0, CH_CAP}) ? CH_CAP : val_sum[CH_W-1:0];
		end
	end

endmodule

// ===== sv/rgb_to_hsv_range_top.sv =====
// Top level of the RGB to HSV converter with threshold windows.
//
//  channel   signals                                     direction
//  -------   -----------------------------------------   ---------
//  input     in_valid, in_ready, red, green, blue          in
//  output    out_valid, out_ready, hue, sat, val,          out
//            hue_low, hue_high, sat_low, sat_high,
//            val_low, val_high
//  config    cfg_we, cfg_index, cfg_data                   in
//
//  One pixel is accepted every clock unless the row holds. Stages: the front
//  stage, nine division cells (one quotient bit each) and the output register.
//  The cells set the latency; each does one compare and subtract per lane.
//  Reset clears all valid bits and sets every margin to 20.
//  When a result waits and out_ready is low, the whole row holds and
//  in_ready drops; it advances again on the cycle the result transfers.
`timescale 1ns / 1ps

module rgb_to_hsv_range_top import rgbhsv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CH_W-1:0]  cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CH_W-1:0]  hue,
	output logic [CH_W-1:0]  sat,
	output logic [CH_W-1:0]  val,
	output logic [CH_W-1:0]  hue_low,
	output logic [CH_W-1:0]  hue_high,
	output logic [CH_W-1:0]  sat_low,
	output logic [CH_W-1:0]  sat_high,
	output logic [CH_W-1:0]  val_low,
	output logic [CH_W-1:0]  val_high
);

	margin_t margin_q;
	logic    en;
	logic    vld   [0:QUO_W];
	cell_t   stage [0:QUO_W];

	// advance the row unless a finished result is still waiting
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// margin registers; an index past the last register is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q.hue <= MARGIN_RESET;
			margin_q.sat <= MARGIN_RESET;
			margin_q.val <= MARGIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HUE_MARGIN: margin_q.hue <= cfg_data;
				REG_SAT_MARGIN: margin_q.sat <= cfg_data;
				REG_VAL_MARGIN: margin_q.val <= cfg_data;
				default: ;
			endcase
		end
	end

	rgbhsv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.red     (red),
		.green   (green),
		.blue    (blue),
		.vld_s1  (vld[0]),
		.data_s1 (stage[0])
	);

	// cell i settles quotient bit QUO_W-1-i, most significant first
	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		rgbhsv_cell #(
			.BIT (QUO_W - 1 - i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (vld[i]),
			.data_i (stage[i]),
			.vld_o  (vld[i+1]),
			.data_o (stage[i+1])
		);
	end

	rgbhsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_i      (vld[QUO_W]),
		.data_i     (stage[QUO_W]),
		.margin     (margin_q),
		.vld_q      (out_valid),
		.hue_q      (hue),
		.sat_q      (sat),
		.val_q      (val),
		.hue_low_q  (hue_low),
		.hue_high_q (hue_high),
		.sat_low_q  (sat_low),
		.sat_high_q (sat_high),
		.val_low_q  (val_low),
		.val_high_q (val_high)
	);

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hue <= 8'd179 && hue_high <= HUE_CAP))
		else $error("hue out of range");

	a_hue_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hue_low <= hue && hue_high >= hue))
		else $error("hue window does not enclose hue");

	a_sat_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sat_low <= sat && sat_high >= sat))
		else $error("saturation window does not enclose saturation");

	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && val == '0) |-> (sat == '0 && hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	a_stall_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(vld[QUO_W]))
		else $error("row advanced while output stalled");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the RGB to HSV range converter.
`timescale 1ns / 1ps

module testbench import rgbhsv_pkg::*; ();

	// Eleven stages from pixel to result; the drain waits out that depth after the last result.
	localparam int PIPE_LATENCY     = 11;
	// Longest quiet stretch of a correct run: the longest idle sender gap, the pipeline,
	// the longest receiver stall, plus a register update. Allow many times that.
	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int RANDOM_PHASES    = 5;
	localparam int PIXELS_PER_PHASE = 80;
	localparam int MAX_GAP          = 14;
	localparam int HSV_FIELDS       = 9;

	// The fourth index decodes to no register; a write there must change nothing.
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

	// How both sides pace their transfers during one phase.
	typedef enum logic [1:0] {
		PACE_FREE,          // both sides idle at random
		PACE_STEADY,        // no idling on either side
		PACE_BACKPRESSURE,  // sender streams, receiver stalls
		PACE_TRICKLE        // sender idles, receiver always ready
	} pace_t;

	typedef struct packed {
		logic [CH_W-1:0] hue;
		logic [CH_W-1:0] sat;
		logic [CH_W-1:0] val;
		logic [CH_W-1:0] hue_low;
		logic [CH_W-1:0] hue_high;
		logic [CH_W-1:0] sat_low;
		logic [CH_W-1:0] sat_high;
		logic [CH_W-1:0] val_low;
		logic [CH_W-1:0] val_high;
	} hsv_window_t;

	typedef struct {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		logic            known;
		hsv_window_t     want;
	} pixel_row_t;

	typedef struct {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		hsv_window_t     want;
	} pending_pixel_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CH_W-1:0]  cfg_data  = '0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic [CH_W-1:0]  red       = '0;
	logic [CH_W-1:0]  green     = '0;
	logic [CH_W-1:0]  blue      = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [CH_W-1:0]  hue;
	logic [CH_W-1:0]  sat;
	logic [CH_W-1:0]  val;
	logic [CH_W-1:0]  hue_low;
	logic [CH_W-1:0]  hue_high;
	logic [CH_W-1:0]  sat_low;
	logic [CH_W-1:0]  sat_high;
	logic [CH_W-1:0]  val_low;
	logic [CH_W-1:0]  val_high;

	// Margins as the block should hold them; reset value is 20.
	logic [CH_W-1:0]  hue_margin_cfg = MARGIN_RESET;
	logic [CH_W-1:0]  sat_margin_cfg = MARGIN_RESET;
	logic [CH_W-1:0]  val_margin_cfg = MARGIN_RESET;

	pace_t            pace = PACE_FREE;
	int               mismatches = 0;
	int               quiet_cycles = 0;
	pixel_row_t       pixel_table[$];
	pending_pixel_t   pending_windows[$];
	string            field_names[HSV_FIELDS] = '{"hue", "sat", "val", "hue_low",
		"hue_high", "sat_low", "sat_high", "val_low", "val_high"};

	always #5 clk = ~clk;

	rgb_to_hsv_range_top u_top (.*);

	function automatic logic [CH_W-1:0] window_low(input int x, input int m);
		int v;
		v = (x > m) ? x - m : 0;
		return v[CH_W-1:0];
	endfunction

	function automatic logic [CH_W-1:0] window_high(input int x, input int m, input int cap);
		int v;
		v = (x + m > cap) ? cap : x + m;
		return v[CH_W-1:0];
	endfunction

	// Compute HSV and the three windows with exact integer arithmetic.
	function automatic hsv_window_t predict_hsv(input logic [CH_W-1:0] r, g, b);
		int ri, gi, bi, mx, mn, d, s, deg, h;
		hsv_window_t p;
		ri = r;
		gi = g;
		bi = b;
		mx = ri;
		mn = ri;
		if (gi > mx) mx = gi;
		if (bi > mx) mx = bi;
		if (gi < mn) mn = gi;
		if (bi < mn) mn = bi;
		d = mx - mn;
		s = (mx == 0) ? 0 : (d * 255) / mx;
		// ties on the largest channel go to red, then green, then blue
		if (d == 0)
			deg = 0;
		else if (ri == mx)
			deg = (gi >= bi) ? ((gi - bi) * 60) / d : (360 * d - (bi - gi) * 60) / d;
		else if (gi == mx)
			deg = (120 * d + (bi - ri) * 60) / d;
		else
			deg = (240 * d + (ri - gi) * 60) / d;
		h = deg / 2;
		p.hue      = h[CH_W-1:0];
		p.sat      = s[CH_W-1:0];
		p.val      = mx[CH_W-1:0];
		p.hue_low  = window_low(h, int'(hue_margin_cfg));
		p.hue_high = window_high(h, int'(hue_margin_cfg), int'(HUE_CAP));
		p.sat_low  = window_low(s, int'(sat_margin_cfg));
		p.sat_high = window_high(s, int'(sat_margin_cfg), int'(CH_CAP));
		p.val_low  = window_low(mx, int'(val_margin_cfg));
		p.val_high = window_high(mx, int'(val_margin_cfg), int'(CH_CAP));
		return p;
	endfunction

	function automatic logic [CH_W-1:0] corner_level(input int pick);
		case (pick)
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic add_row(input int r, g, b);
		pixel_row_t row;
		row.r     = r[CH_W-1:0];
		row.g     = g[CH_W-1:0];
		row.b     = b[CH_W-1:0];
		row.known = 1'b0;
		row.want  = '0;
		pixel_table.insert(pixel_table.size(), row);
	endtask

	task automatic add_known(input int r, g, b, h, s, v, hl, hh, sl, sh, vl, vh);
		pixel_row_t row;
		row.r     = r[CH_W-1:0];
		row.g     = g[CH_W-1:0];
		row.b     = b[CH_W-1:0];
		row.known = 1'b1;
		row.want  = {h[CH_W-1:0], s[CH_W-1:0], v[CH_W-1:0], hl[CH_W-1:0], hh[CH_W-1:0],
			sl[CH_W-1:0], sh[CH_W-1:0], vl[CH_W-1:0], vh[CH_W-1:0]};
		pixel_table.insert(pixel_table.size(), row);
	endtask

	// Present one pixel, hold it until the transfer, then queue its expected window.
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b, input hsv_window_t want);
		int gap;
		pending_pixel_t entry;
		gap = (pace == PACE_FREE || pace == PACE_TRICKLE) ? $urandom_range(0, MAX_GAP) : 0;
		repeat (gap) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		entry.r    = r;
		entry.g    = g;
		entry.b    = b;
		entry.want = want;
		pending_windows.insert(pending_windows.size(), entry);
	endtask

	// Drive one register write; the caller drops the write enable after a batch.
	task automatic write_margin(input logic [IDX_W-1:0] idx, input logic [CH_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_HUE_MARGIN: hue_margin_cfg = data;
			REG_SAT_MARGIN: sat_margin_cfg = data;
			REG_VAL_MARGIN: val_margin_cfg = data;
			default: ;
		endcase
	endtask

	// Write all three margins, then poke the unused index with junk that must be dropped.
	task automatic set_margins(input int h, s, v);
		write_margin(REG_HUE_MARGIN, h[CH_W-1:0]);
		write_margin(REG_SAT_MARGIN, s[CH_W-1:0]);
		write_margin(REG_VAL_MARGIN, v[CH_W-1:0]);
		write_margin(REG_SPARE, 8'($urandom_range(0, 255)));
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// Wait for every queued window to come back, then let the pipeline settle.
	task automatic drain_pipeline();
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// Result side: stall a random number of cycles per result when the pace allows,
	// then take the next transfer and compare it field by field with the oldest expectation.
	initial begin : result_side
		int stall;
		hsv_window_t got;
		pending_pixel_t exp_pixel;
		forever begin
			stall = (pace == PACE_FREE || pace == PACE_BACKPRESSURE) ?
				$urandom_range(0, MAX_GAP) : 0;
			repeat (stall) @(negedge clk) out_ready <= 1'b0;
			@(negedge clk) out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got = {hue, sat, val, hue_low, hue_high, sat_low, sat_high, val_low, val_high};
			if (pending_windows.size() == 0) begin
				report_mismatch("result transferred with no pixel outstanding");
			end else begin
				exp_pixel = pending_windows.pop_front();
				for (int k = 0; k < HSV_FIELDS; k++) begin
					if (got[(HSV_FIELDS-1-k)*CH_W +: CH_W] !==
							exp_pixel.want[(HSV_FIELDS-1-k)*CH_W +: CH_W])
						report_mismatch($sformatf("rgb %0d,%0d,%0d %s: got %0d expected %0d",
							exp_pixel.r, exp_pixel.g, exp_pixel.b, field_names[k],
							got[(HSV_FIELDS-1-k)*CH_W +: CH_W],
							exp_pixel.want[(HSV_FIELDS-1-k)*CH_W +: CH_W]));
				end
			end
		end
	end

	// Watchdog: end the run once no transfer has happened for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int phase, hi, lo, v;
		logic [CH_W-1:0] r, g, b;
		pixel_row_t row;

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed pixels at the reset margins of 20. Primaries and the gray
		// extremes carry their window typed in; the rest go through the predictor.
		add_known(0, 0, 0,       0,   0,   0,   0,   20,  0,   20,  0,   20);  // black
		add_known(255, 255, 255, 0,   0,   255, 0,   20,  0,   20,  235, 255); // white
		add_known(255, 0, 0,     0,   255, 255, 0,   20,  235, 255, 235, 255); // red
		add_known(0, 255, 0,     60,  255, 255, 40,  80,  235, 255, 235, 255); // green
		add_known(0, 0, 255,     120, 255, 255, 100, 140, 235, 255, 235, 255); // blue
		add_row(128, 128, 128);  // mid gray, hue zero
		add_row(255, 255, 0);    // red and green tie for largest
		add_row(0, 255, 255);    // green and blue tie for largest
		add_row(255, 0, 255);    // red and blue tie, green below blue wraps past 360
		add_row(255, 0, 1);      // hue just short of a full turn, high bound capped
		add_row(200, 10, 50);    // red largest, green below blue
		add_row(200, 50, 10);
		add_row(10, 200, 50);
		add_row(50, 200, 10);
		add_row(50, 10, 200);
		add_row(10, 50, 200);
		add_row(1, 0, 0);        // darkest non-black pixels
		add_row(1, 1, 0);
		add_row(0, 0, 1);
		add_row(0, 1, 1);
		add_row(255, 254, 254);  // faintest saturation
		add_row(254, 255, 0);
		add_row(255, 128, 0);
		add_row(90, 37, 90);
		foreach (pixel_table[i]) begin
			row = pixel_table[i];
			send_pixel(row.r, row.g, row.b, row.known ? row.want : predict_hsv(row.r, row.g, row.b));
		end
		@(negedge clk) in_valid <= 1'b0;

		// Random phases: margins change only with the pipeline empty, and the
		// phases take the four pacing modes in turn, the last repeating the first.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_pipeline();
			case (phase)
				0: set_margins(0, 0, 0);
				1: set_margins(255, 255, 255);
				2: set_margins(180, 255, 0);
				3: set_margins($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255));
				default: set_margins($urandom_range(0, 180), 20, $urandom_range(0, 255));
			endcase
			pace = pace_t'(phase[1:0]);
			for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
				case ($urandom_range(0, 9))
					0: begin  // gray
						v = $urandom_range(0, 255);
						r = v[CH_W-1:0];
						g = v[CH_W-1:0];
						b = v[CH_W-1:0];
					end
					1: begin  // two channels tie for largest
						hi = $urandom_range(1, 255);
						lo = $urandom_range(0, hi - 1);
						case ($urandom_range(0, 2))
							0: begin r = hi[CH_W-1:0]; g = hi[CH_W-1:0]; b = lo[CH_W-1:0]; end
							1: begin r = lo[CH_W-1:0]; g = hi[CH_W-1:0]; b = hi[CH_W-1:0]; end
							default: begin r = hi[CH_W-1:0]; g = lo[CH_W-1:0]; b = hi[CH_W-1:0]; end
						endcase
					end
					2: begin  // channels at the ends of their range
						r = corner_level($urandom_range(0, 3));
						g = corner_level($urandom_range(0, 3));
						b = corner_level($urandom_range(0, 3));
					end
					3: begin  // near black
						r = 8'($urandom_range(0, 3));
						g = 8'($urandom_range(0, 3));
						b = 8'($urandom_range(0, 3));
					end
					default: begin
						r = 8'($urandom_range(0, 255));
						g = 8'($urandom_range(0, 255));
						b = 8'($urandom_range(0, 255));
					end
				endcase
				send_pixel(r, g, b, predict_hsv(r, g, b));
			end
			@(negedge clk) in_valid <= 1'b0;
		end

		drain_pipeline();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/rgbhsv_pkg.sv
sv/rgbhsv_front.sv
sv/rgbhsv_cell.sv
sv/rgbhsv_back.sv
sv/rgb_to_hsv_range_top.sv
tb/testbench.sv
